[hw/rtl/pwsfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsfr_pkg
// shared types and constants for the pulse-width serial frame receiver
// ----------------------------------------------------------------------------
package pwsfr_pkg;

  localparam int FRAME_BYTES_DEF = 11;
  localparam int DATA_BITS_DEF   = 8;
  localparam int TICK_SHIFT_DEF  = 3;

  // depth of the queue between the edge front end and the decoder
  localparam int QUEUE_DEPTH = 2;

  // reset values of the configuration registers
  localparam logic [7:0] BIT_ONE_THR_RST  = 8'd16;
  localparam logic [7:0] LINE_LOW_THR_RST = 8'd26;
  localparam logic [7:0] FRAME_ID_RST     = 8'd0;
  localparam logic [7:0] FRAME_LEN_RST    = 8'd0;

  typedef enum logic [1:0] {
    REG_BIT_ONE_THR  = 2'd0,
    REG_LINE_LOW_THR = 2'd1,
    REG_FRAME_ID     = 2'd2,
    REG_FRAME_LEN    = 2'd3
  } reg_idx_t;

  // one measured pulse pair, or a plain timestamp event when decode is low
  typedef struct packed {
    logic       decode;
    logic [7:0] low_us;
    logic [7:0] high_us;
  } sym_t;

  typedef struct packed {
    logic [7:0] bit_one_thr;
    logic [7:0] line_low_thr;
    logic [7:0] frame_id;
    logic [7:0] frame_len;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hw/rtl/pwsfr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsfr_front
// edge front end: timestamps edges and measures low and high pulse widths
// ----------------------------------------------------------------------------
module pwsfr_front #(
  parameter int TICK_SHIFT = pwsfr_pkg::TICK_SHIFT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              edge_rising,
  input  logic [15:0]       capture_time,
  output pwsfr_pkg::sym_t   sym
);

  logic [15:0] last_fall_time;
  logic [15:0] last_rise_time;
  logic [15:0] low_width_ticks;
  logic        rise_seen;

  logic [15:0] low_next;
  logic [15:0] high_ticks;
  logic [15:0] low_scaled;
  logic [15:0] high_scaled;

  assign low_next    = capture_time - last_fall_time;
  assign high_ticks  = capture_time - last_rise_time;
  assign low_scaled  = low_width_ticks >> TICK_SHIFT;
  assign high_scaled = high_ticks >> TICK_SHIFT;

  always_comb begin
    sym.decode  = !edge_rising && rise_seen;
    sym.low_us  = low_scaled[7:0];
    sym.high_us = high_scaled[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_fall_time  <= '0;
      last_rise_time  <= '0;
      low_width_ticks <= '0;
      rise_seen       <= 1'b0;
    end else if (accept) begin
      if (edge_rising) begin
        last_rise_time  <= capture_time;
        low_width_ticks <= low_next;
        rise_seen       <= 1'b1;
      end else begin
        last_fall_time <= capture_time;
        rise_seen      <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/pwsfr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsfr_queue
// short register queue between front end and decoder
// ----------------------------------------------------------------------------
module pwsfr_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = pwsfr_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rdata,
  output pwsfr_pkg::q_stat_t   stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign rdata      = slots[rptr];
  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_SLOT) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST_SLOT) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[hw/rtl/pwsfr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsfr_back
// decoder: bit slicing, byte assembly, framer and output register
// ----------------------------------------------------------------------------
module pwsfr_back #(
  parameter int FRAME_BYTES = pwsfr_pkg::FRAME_BYTES_DEF,
  parameter int DATA_BITS   = pwsfr_pkg::DATA_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pwsfr_pkg::cfg_t    cfg,
  input  pwsfr_pkg::q_stat_t q_stat,
  input  pwsfr_pkg::sym_t    sym,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               line_level,
  output logic               byte_done,
  output logic [7:0]         byte_value,
  output logic               frame_byte_valid,
  output logic [3:0]         frame_byte_index,
  output logic               frame_last
);

  localparam logic [3:0] LAST_POS  = 4'(FRAME_BYTES - 1);
  localparam logic [3:0] DATA_CNT  = 4'(DATA_BITS);

  logic       line_out;
  logic       in_byte;
  logic [3:0] bit_index;
  logic [7:0] byte_shift;
  logic [3:0] frame_position;

  logic       line_next;
  logic       in_byte_next;
  logic [3:0] bit_index_next;
  logic [7:0] byte_shift_next;
  logic [3:0] frame_position_next;
  logic       done;
  logic       accepted;
  logic [3:0] index;
  logic       last;
  logic [7:0] diff;
  logic       one;
  logic [3:0] bit_inc;

  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  always_comb begin
    diff    = (sym.low_us > sym.high_us) ? sym.low_us - sym.high_us
                                         : sym.high_us - sym.low_us;
    one     = (diff >= cfg.bit_one_thr);
    bit_inc = bit_index + 4'd1;

    line_next       = line_out;
    in_byte_next    = in_byte;
    bit_index_next  = bit_index;
    byte_shift_next = byte_shift;
    done            = 1'b0;

    if (sym.decode) begin
      line_next = !(sym.low_us > cfg.line_low_thr);
      if (!in_byte) begin
        // a zero while idle is the start bit
        if (!one) begin
          in_byte_next   = 1'b1;
          bit_index_next = '0;
        end
      end else begin
        if (!bit_index[3]) begin
          byte_shift_next[bit_index[2:0]] = one;
        end
        bit_index_next = bit_inc;
        if (bit_inc >= DATA_CNT) begin
          in_byte_next = 1'b0;
          done         = 1'b1;
        end
      end
    end

    frame_position_next = frame_position;
    accepted            = 1'b0;
    index               = '0;
    last                = 1'b0;
    if (done) begin
      priority if (frame_position == 4'd0) begin
        if (byte_shift_next == cfg.frame_id) begin
          accepted            = 1'b1;
          frame_position_next = 4'd1;
        end
      end else if (frame_position == 4'd1) begin
        if (byte_shift_next == cfg.frame_len) begin
          accepted            = 1'b1;
          index               = 4'd1;
          frame_position_next = 4'd2;
        end else begin
          frame_position_next = '0;
        end
      end else if (frame_position < LAST_POS) begin
        accepted            = 1'b1;
        index               = frame_position;
        frame_position_next = frame_position + 4'd1;
      end else if (frame_position == LAST_POS) begin
        accepted            = 1'b1;
        index               = frame_position;
        last                = 1'b1;
        frame_position_next = '0;
      end else begin
        frame_position_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_out       <= 1'b1;
      in_byte        <= 1'b0;
      bit_index      <= '0;
      byte_shift     <= '0;
      frame_position <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        line_out       <= line_next;
        in_byte        <= in_byte_next;
        bit_index      <= bit_index_next;
        byte_shift     <= byte_shift_next;
        frame_position <= frame_position_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_level       <= line_next;
      byte_done        <= done;
      byte_value       <= done ? byte_shift_next : 8'd0;
      frame_byte_valid <= accepted;
      frame_byte_index <= index;
      frame_last       <= last;
    end
  end

endmodule

[hw/rtl/pulse_width_serial_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_serial_frame_receiver
// decodes pulse-width coded serial bytes from edge captures and frames them
// ----------------------------------------------------------------------------
//
// channel   dir  handshake              beat contents
// --------  ---  ---------------------  ----------------------------------------
// in        in   in_valid / in_stall    edge_rising, capture_time
// out       out  out_valid / out_stall  line_level, byte_done, byte_value,
//                                       frame_byte_valid, frame_byte_index,
//                                       frame_last
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one result beat per input beat; one beat per cycle sustained while out_stall
// is low; the edge front end writes each input beat into the queue, and the
// decoder writes its result into the output register
// the front end stalls only when the two-entry queue is full; the decoder
// keeps draining into the output register while the previous result is taken
// synchronous reset: line idles high, framer hunts for the frame id, no
// pulse measured yet; configuration registers return to their defaults
// cfg_ready is always high
//
module pulse_width_serial_frame_receiver #(
  parameter int FRAME_BYTES = pwsfr_pkg::FRAME_BYTES_DEF,
  parameter int DATA_BITS   = pwsfr_pkg::DATA_BITS_DEF,
  parameter int TICK_SHIFT  = pwsfr_pkg::TICK_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // edge capture beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        edge_rising,
  input  logic [15:0] capture_time,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic        line_level,
  output logic        byte_done,
  output logic [7:0]  byte_value,
  output logic        frame_byte_valid,
  output logic [3:0]  frame_byte_index,
  output logic        frame_last,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int SYM_W = $bits(pwsfr_pkg::sym_t);

  pwsfr_pkg::cfg_t    cfg;
  pwsfr_pkg::q_stat_t q_stat;
  pwsfr_pkg::sym_t    front_sym;
  pwsfr_pkg::sym_t    head_sym;
  logic               in_accept;
  logic               pop;

  // the queue never needs more than its depth, so stall only when full
  assign in_stall  = q_stat.full;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_one_thr  <= pwsfr_pkg::BIT_ONE_THR_RST;
      cfg.line_low_thr <= pwsfr_pkg::LINE_LOW_THR_RST;
      cfg.frame_id     <= pwsfr_pkg::FRAME_ID_RST;
      cfg.frame_len    <= pwsfr_pkg::FRAME_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pwsfr_pkg::reg_idx_t'(cfg_index))
        pwsfr_pkg::REG_BIT_ONE_THR:  cfg.bit_one_thr  <= cfg_data;
        pwsfr_pkg::REG_LINE_LOW_THR: cfg.line_low_thr <= cfg_data;
        pwsfr_pkg::REG_FRAME_ID:     cfg.frame_id     <= cfg_data;
        pwsfr_pkg::REG_FRAME_LEN:    cfg.frame_len    <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end: timestamps and pulse widths
  pwsfr_front #(
    .TICK_SHIFT (TICK_SHIFT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .edge_rising  (edge_rising),
    .capture_time (capture_time),
    .sym          (front_sym)
  );

  // measured pulses waiting for the decoder
  pwsfr_queue #(
    .WIDTH (SYM_W),
    .DEPTH (pwsfr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (in_accept),
    .wdata (front_sym),
    .pop   (pop),
    .rdata (head_sym),
    .stat  (q_stat)
  );

  // back end: bits, bytes, frame and the output register
  pwsfr_back #(
    .FRAME_BYTES (FRAME_BYTES),
    .DATA_BITS   (DATA_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_stat           (q_stat),
    .sym              (head_sym),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .line_level       (line_level),
    .byte_done        (byte_done),
    .byte_value       (byte_value),
    .frame_byte_valid (frame_byte_valid),
    .frame_byte_index (frame_byte_index),
    .frame_last       (frame_last)
  );

  // a result without a finished byte carries no frame byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_done |-> !frame_byte_valid && byte_value == 8'd0)
    else $error("frame byte flagged without a finished byte");

  // the last-byte flag only sits on the final frame position
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |->
      frame_byte_valid && frame_byte_index == 4'(FRAME_BYTES - 1))
    else $error("frame_last on a byte that is not the last of the frame");

  // nothing comes out in the cycle after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat straight after reset");

endmodule
